@@ rtl/core/grid_coin_path_max_dp_defines.svh @@
// Assertion macros used by the coin path RTL.
`ifndef GRID_COIN_PATH_MAX_DP_DEFINES_SVH
`define GRID_COIN_PATH_MAX_DP_DEFINES_SVH

`ifndef SYNTHESIS
`define GCPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCPM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GCPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCPM_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/gcpm_pkg.sv @@
// Types and constants of the coin path block.
package gcpm_pkg;

  localparam int unsigned CoinW   = 8;
  localparam int unsigned SumW    = 19;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned OutDataW = 24;

  localparam logic [SumW-1:0] SumLimit  = {SumW{1'b1}};
  localparam logic [CfgW-1:0] CfgSizeRst = CfgW'(1024);

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } gcpm_cfg_e;

  // Control that travels with a cell from the read stage to the update stage.
  typedef struct packed {
    logic [CoinW-1:0] coins;
    logic             blocked;
    logic             first_row;
    logic             first_col;
    logic             end_grid;
    logic             hit;
  } gcpm_s1_t;

endpackage

@@ rtl/core/grid_coin_path_max_dp.sv @@
// Coin path maximum over a raster cell stream, with a one-row line buffer.
// A cell is registered in the update stage and its result in the output register.
// Throughput: one cell per cycle when not stalled; the line buffer has one read and
// one write port, and a cell in the column of the one ahead takes the forwarded sum.
// Reset: position, left sum and cut flags clear, grid size registers load 1024;
// the line buffer is not cleared, each row is written before it is read.
`include "grid_coin_path_max_dp_defines.svh"

module grid_coin_path_max_dp #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [gcpm_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gcpm_pkg::CoinW-1:0]      s_axis_tdata,   // [7:0] coin_count
  input  logic                            s_axis_tuser,   // [0] blocked
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gcpm_pkg::OutDataW-1:0]   m_axis_tdata,   // [18:0] best_sum, rest zero
  output logic                            m_axis_tlast    // last_cell
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CLW_C = (CW + 1 > gcpm_pkg::CfgW) ? CW + 1 : gcpm_pkg::CfgW;
  localparam int unsigned CLW_R = (RW + 1 > gcpm_pkg::CfgW) ? RW + 1 : gcpm_pkg::CfgW;
  localparam int unsigned SW = gcpm_pkg::SumW;

  // configuration
  logic [gcpm_pkg::CfgW-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gcpm_pkg::CfgSizeRst;
      cols_q <= gcpm_pkg::CfgSizeRst;
    end else if (cfg_we_i) begin
      case (gcpm_pkg::gcpm_cfg_e'(cfg_idx_i))
        gcpm_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        gcpm_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CLW_C-1:0] cols_ext, cols_eff;
  logic [CLW_R-1:0] rows_ext, rows_eff;
  logic [CW-1:0]    cols_last;
  logic [RW-1:0]    rows_last;

  always_comb begin
    cols_ext = CLW_C'(cols_q);
    rows_ext = CLW_R'(rows_q);
    if (cols_ext == '0) begin
      cols_eff = CLW_C'(1);
    end else if (cols_ext > CLW_C'(MAX_COLS)) begin
      cols_eff = CLW_C'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_eff = CLW_R'(1);
    end else if (rows_ext > CLW_R'(MAX_ROWS)) begin
      rows_eff = CLW_R'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    cols_last = CW'(cols_eff - CLW_C'(1));
    rows_last = RW'(rows_eff - CLW_R'(1));
  end

  // handshake and stage control
  logic               s1_valid_q;
  gcpm_pkg::gcpm_s1_t s1_q, s1_d;
  logic [CW-1:0]      s1_col_q;
  logic               out_valid_q;
  logic [SW-1:0]      out_sum_q;
  logic               out_last_q;
  logic               s1_fire, s_fire;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // raster position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          end_row, end_grid;

  always_comb begin
    end_row  = col_q >= cols_last;
    end_grid = end_row && (row_q >= rows_last);
    col_d = col_q;
    row_d = row_q;
    if (s_fire) begin
      if (end_grid) begin
        col_d = '0;
        row_d = '0;
      end else if (end_row) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    s1_d.coins     = s_axis_tdata;
    s1_d.blocked   = s_axis_tuser;
    s1_d.first_row = row_q == '0;
    s1_d.first_col = col_q == '0;
    s1_d.end_grid  = end_grid;
    // the cell ahead writes this column in the same cycle as the read
    s1_d.hit       = s1_fire && (s1_col_q == col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_q     <= s1_d;
      s1_col_q <= col_q;
    end
  end

  // line buffer: previous row's sums
  logic [SW-1:0] line_mem [MAX_COLS];
  logic [SW-1:0] rdata_q;
  logic [SW-1:0] v;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_col_q] <= v;
    end
    if (s_fire) begin
      rdata_q <= line_mem[col_q];
    end
  end

  // update stage
  logic [SW-1:0] left_q, prev_v_q;
  logic          top_cut_q, left_cut_q;
  logic          top_cut_d, left_cut_d;
  logic [SW-1:0] above, base;
  logic [SW:0]   sum;
  logic [SW-1:0] sat;

  always_comb begin
    above = s1_q.hit ? prev_v_q : rdata_q;
    if (s1_q.first_row) begin
      base = left_q;
    end else if (s1_q.first_col) begin
      base = above;
    end else begin
      base = (above > left_q) ? above : left_q;
    end
    sum = {1'b0, base} + (SW + 1)'(s1_q.coins);
    sat = (sum > (SW + 1)'(gcpm_pkg::SumLimit)) ? gcpm_pkg::SumLimit : sum[SW-1:0];

    top_cut_d  = top_cut_q;
    left_cut_d = left_cut_q;
    if (s1_q.first_row && s1_q.first_col) begin
      if (s1_q.blocked) begin
        v          = '0;
        top_cut_d  = 1'b1;
        left_cut_d = 1'b1;
      end else begin
        v = SW'(s1_q.coins);
      end
    end else if (s1_q.first_row) begin
      if (s1_q.blocked || top_cut_q) begin
        v         = '0;
        top_cut_d = 1'b1;
      end else begin
        v = sat;
      end
    end else if (s1_q.first_col) begin
      if (s1_q.blocked || left_cut_q) begin
        v          = '0;
        left_cut_d = 1'b1;
      end else begin
        v = sat;
      end
    end else begin
      v = s1_q.blocked ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      top_cut_q   <= 1'b0;
      left_cut_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        // drop the row state at the end of the grid
        left_q     <= s1_q.end_grid ? '0 : v;
        top_cut_q  <= s1_q.end_grid ? 1'b0 : top_cut_d;
        left_cut_q <= s1_q.end_grid ? 1'b0 : left_cut_d;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      prev_v_q   <= v;
      out_sum_q  <= v;
      out_last_q <= s1_q.end_grid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = gcpm_pkg::OutDataW'(out_sum_q);
  assign m_axis_tlast  = out_last_q;

  `GCPM_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (s1_valid_q && !s1_fire) |-> !s_axis_tready, "input taken while update stage stalls")
  `GCPM_ASSERT(a_read_data_held, clk_i, rst_ni, (s1_valid_q && !s1_fire) |=> $stable(rdata_q), "line buffer data lost during stall")
  `GCPM_ASSERT(a_grid_wraps, clk_i, rst_ni, (s_fire && end_grid) |=> (col_q == '0 && row_q == '0), "position not cleared at end of grid")
  `GCPM_ASSERT_NR(a_accept_fills_stage, clk_i, (rst_ni && s_fire) |=> s1_valid_q, "accepted cell missing from update stage")

endmodule
